// ===== src/iia_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iia_pkg
// Shared types and constants of the insertable integer array.
// ----------------------------------------------------------------------------
package iia_pkg;

  // default list depth
  localparam int IIA_CAPACITY = 64;

  // field widths
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 7;
  localparam int FILL_W  = 7;

  // requested action
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  // result status
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage : iia_pkg
`default_nettype wire

// ===== src/insertable_int_array.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// insertable_int_array
// Ordered list of signed 32-bit words in a single-port-write memory with a
// fill count: append, insert, remove and read by position.
// ----------------------------------------------------------------------------
//
// channel   dir   tdata (low bit up)                    tuser
// s_*       in    value[31:0], index[38:32], pad 0      action[1:0]
// m_*       out   read_value[31:0], fill_count[38:32]   status[1:0]
//
// Append, refused requests, insert at the end and remove of the last entry
// move no entries; a read waits on the registered memory read; insert moves
// count-index entries and remove moves count-index-1. Each moved entry costs
// a memory read followed by a write through the one shared pointer adder.
// Reset clears the fill count and the sequencer; memory contents are not
// cleared and need no pass. A waiting result holds the sequencer in its
// result state until m_tready; s_tready is high only when idle.
//
module insertable_int_array
  import iia_pkg::*;
#(
  parameter int CAPACITY = IIA_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // value[31:0], index[38:32], zero pad
  input  wire logic [1:0]  s_tuser,   // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0] m_tdata,        // read_value[31:0], fill_count[38:32], zero pad
  output logic [1:0]  m_tuser         // status[1:0]
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SH_RD, S_SH_WR, S_WR_VAL, S_RD_DATA, S_RESULT
  } state_t;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [AW-1:0]           ptr;
  logic [AW-1:0]           idx_q;
  logic signed [VALUE_W-1:0] val_q;
  action_t                 act_q;
  logic [VALUE_W-1:0]      res_value;
  status_t                 res_status;

  // memory
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] wdata;

  // input fields
  action_t                   in_act;
  logic signed [VALUE_W-1:0] in_value;
  logic [INDEX_W-1:0]        in_index;
  logic                      s_accept;

  // decode
  logic [CMPW-1:0] idx_w;
  logic [CMPW-1:0] cnt_w;
  logic            full;
  status_t         dec_status;
  logic            at_end;
  logic            last_entry;
  logic            ins_last;
  logic            rem_last;

  assign in_act   = action_t'(s_tuser);
  assign in_value = s_tdata[31:0];
  assign in_index = s_tdata[38:32];
  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;

  // range and full checks of the incoming word
  always_comb begin
    idx_w      = CMPW'(in_index);
    cnt_w      = CMPW'(count);
    full       = (count == CW'(CAPACITY));
    at_end     = (idx_w == cnt_w);
    last_entry = ((idx_w + CMPW'(1)) == cnt_w);
    unique case (in_act)
      ACT_APPEND: dec_status = full ? ST_FULL : ST_DONE;
      ACT_INSERT: dec_status = (idx_w > cnt_w) ? ST_INDEX : (full ? ST_FULL : ST_DONE);
      ACT_REMOVE: dec_status = (idx_w >= cnt_w) ? ST_INDEX : ST_DONE;
      ACT_READ:   dec_status = (idx_w >= cnt_w) ? ST_INDEX : ST_DONE;
      default:    dec_status = ST_INDEX;
    endcase
  end

  // end-of-shift tests on the shared pointer
  assign ins_last = (ptr == (idx_q + AW'(1)));
  assign rem_last = ((CW'(ptr) + CW'(2)) == count);

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = rdata;
    raddr = ptr;
    unique case (state)
      S_IDLE: begin
        raddr = AW'(in_index);
        if (s_accept && dec_status == ST_DONE) begin
          if (in_act == ACT_APPEND) begin
            we    = 1'b1;
            waddr = count[AW-1:0];
            wdata = in_value;
          end else if (in_act == ACT_INSERT && at_end) begin
            we    = 1'b1;
            waddr = count[AW-1:0];
            wdata = in_value;
          end
        end
      end
      S_SH_RD: begin
        raddr = (act_q == ACT_INSERT) ? (ptr - AW'(1)) : (ptr + AW'(1));
      end
      S_SH_WR: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = rdata;
      end
      S_WR_VAL: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = val_q;
      end
      S_RD_DATA, S_RESULT: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // storage with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_RESULT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            idx_q      <= AW'(in_index);
            val_q      <= in_value;
            act_q      <= in_act;
            res_status <= dec_status;
            res_value  <= '0;
            if (dec_status != ST_DONE) begin
              state <= S_RESULT;
            end else begin
              unique case (in_act)
                ACT_APPEND: begin
                  count <= count + CW'(1);
                  state <= S_RESULT;
                end
                ACT_INSERT: begin
                  if (at_end) begin
                    count <= count + CW'(1);
                    state <= S_RESULT;
                  end else begin
                    ptr   <= count[AW-1:0];
                    state <= S_SH_RD;
                  end
                end
                ACT_REMOVE: begin
                  if (last_entry) begin
                    count <= count - CW'(1);
                    state <= S_RESULT;
                  end else begin
                    ptr   <= AW'(in_index);
                    state <= S_SH_RD;
                  end
                end
                ACT_READ: state <= S_RD_DATA;
                default:  state <= S_RESULT;
              endcase
            end
          end
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          if (act_q == ACT_INSERT) begin
            if (ins_last) begin
              state <= S_WR_VAL;
            end else begin
              ptr   <= ptr - AW'(1);
              state <= S_SH_RD;
            end
          end else begin
            if (rem_last) begin
              count <= count - CW'(1);
              state <= S_RESULT;
            end else begin
              ptr   <= ptr + AW'(1);
              state <= S_SH_RD;
            end
          end
        end
        S_WR_VAL: begin
          count <= count + CW'(1);
          state <= S_RESULT;
        end
        S_RD_DATA: begin
          res_value <= rdata;
          state     <= S_RESULT;
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, cnt_w[FILL_W-1:0], res_value};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // memory is written only during an accepted word or its sequence
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> (s_accept || state != S_IDLE))
    else $error("memory write while idle");

  // a new result is only launched from the result state
  a_launch: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_RESULT))
    else $error("result launched outside result state");

  // one word at a time: ready drops after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("ready held after accept");

endmodule : insertable_int_array
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertable_int_array testbench
// Drives append, insert, remove and read requests through the stream ports
// and checks every response word against a shadow copy of the list held here.
// Stimulus: a short directed run over the edges of each action, then random
// phases that grow, drain and churn the list so that full and empty lists,
// boundary positions and out-of-range positions all come up. Both sides
// insert random pauses, with calm stretches between them.
// ----------------------------------------------------------------------------
module testbench;
  import iia_pkg::*;

  // response word fields
  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    status_t            status;
    logic [FILL_W-1:0]  fill_count;
  } list_result_t;

  // list shadow: tracks the stored words and queues the expected responses
  class list_shadow;
    logic [VALUE_W-1:0] words [IIA_CAPACITY];
    int unsigned        fill;
    list_result_t       pending [$];
    int unsigned        mismatches;
    int unsigned        compared;
    int unsigned        action_hits [4];
    int unsigned        status_hits [4];

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    // apply one accepted request and queue the response it must produce
    function void apply_request(action_t act, logic [VALUE_W-1:0] val,
                                logic [INDEX_W-1:0] idx);
      list_result_t res;
      int unsigned  pos;
      int unsigned  i;
      pos            = 32'(idx);
      res.read_value = '0;
      res.status     = ST_DONE;
      case (act)
        ACT_APPEND: begin
          if (fill >= IIA_CAPACITY) res.status = ST_FULL;
          else begin
            words[fill] = val;
            fill++;
          end
        end
        ACT_INSERT: begin
          // position check wins over the full check
          if (pos > fill) res.status = ST_INDEX;
          else if (fill >= IIA_CAPACITY) res.status = ST_FULL;
          else begin
            for (i = fill; i > pos; i--) words[i] = words[i - 1];
            words[pos] = val;
            fill++;
          end
        end
        ACT_REMOVE: begin
          if (pos >= fill) res.status = ST_INDEX;
          else begin
            for (i = pos; i + 1 < fill; i++) words[i] = words[i + 1];
            fill--;
          end
        end
        default: begin
          if (pos >= fill) res.status = ST_INDEX;
          else res.read_value = words[pos];
        end
      endcase
      res.fill_count = FILL_W'(fill);
      action_hits[act]++;
      status_hits[res.status]++;
      pending.push_back(res);
    endfunction

    // compare one accepted response word with the oldest expectation
    function void check_response(logic [VALUE_W-1:0] rv, logic [1:0] st,
                                 logic [FILL_W-1:0] fc);
      list_result_t exp;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected word: read_value=%h status=%0d fill=%0d",
                       rv, st, fc));
      end else begin
        exp = pending.pop_front();
        compared++;
        if (rv !== exp.read_value || st !== exp.status || fc !== exp.fill_count)
          flag($sformatf({"mismatch on word %0d: expected read_value=%h status=%0d",
                          " fill=%0d, got read_value=%h status=%0d fill=%0d"},
                         compared, exp.read_value, exp.status, exp.fill_count,
                         rv, st, fc));
      end
    endfunction

    function void check_drained();
      if (pending.size() != 0)
        flag($sformatf("%0d responses never arrived", pending.size()));
    endfunction
  endclass

  // stimulus phase shapes
  typedef enum int {PH_GROW, PH_SHRINK, PH_CHURN} phase_t;

  localparam int RANDOM_ITEMS = 1750;
  localparam int MAX_PAUSE    = 14;
  localparam int DRAIN_CYCLES = 2 * IIA_CAPACITY + 12;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // value[31:0], index[38:32], zero pad
  logic [1:0]  s_tuser  = '0;   // action[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // read_value[31:0], fill_count[38:32], zero pad
  logic [1:0]  m_tuser;         // status[1:0]

  list_shadow  sb;
  bit          send_calm  = 1'b0;
  bit          take_calm  = 1'b0;
  int unsigned stall_left = 0;
  int unsigned sent       = 0;

  insertable_int_array dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  always #5 clk = ~clk;

  // response side: check each accepted word, then stall for a random while
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid === 1'b1 && m_tready) begin
        sb.check_response(m_tdata[31:0], m_tuser, m_tdata[38:32]);
        if ($urandom_range(0, 59) == 0) take_calm = !take_calm;
        stall_left = take_calm ? 0 : $urandom_range(0, MAX_PAUSE);
        m_tready <= (stall_left == 0);
      end else if (!m_tready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) m_tready <= 1'b1;
      end
    end
  end

  // send one request word after a random pause
  task automatic send_request(input action_t act, input logic [VALUE_W-1:0] val,
                              input logic [INDEX_W-1:0] idx);
    int unsigned pause;
    if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
    pause = send_calm ? 0 : $urandom_range(0, MAX_PAUSE);
    if (pause > 0) begin
      s_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, idx, val};
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.apply_request(act, val, idx);
    sent++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 39))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // mostly legal positions, some exactly one past the edge, some anywhere
  function automatic logic [INDEX_W-1:0] pick_index(action_t act, int unsigned fill);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (act == ACT_APPEND || roll < 8) return INDEX_W'($urandom_range(0, 127));
    if (act == ACT_INSERT) begin
      if (roll < 15) return INDEX_W'(fill + 1);
      return INDEX_W'($urandom_range(0, fill));
    end
    if (roll < 15 || fill == 0) return INDEX_W'(fill);
    return INDEX_W'($urandom_range(0, fill - 1));
  endfunction

  // directed edges: empty list, extreme values, both ends, out of range
  task automatic run_directed();
    int i;
    send_request(ACT_READ,   32'h1111_1111, 7'd0);
    send_request(ACT_REMOVE, 32'h2222_2222, 7'd0);
    send_request(ACT_INSERT, 32'h3333_3333, 7'd1);
    send_request(ACT_INSERT, 32'h4444_4444, 7'd64);
    send_request(ACT_INSERT, 32'h7fff_ffff, 7'd0);
    send_request(ACT_APPEND, 32'h8000_0000, 7'd127);
    send_request(ACT_APPEND, 32'h0000_0000, 7'd0);
    send_request(ACT_APPEND, 32'hffff_ffff, 7'd64);
    send_request(ACT_INSERT, 32'h1234_5678, 7'd4);
    send_request(ACT_INSERT, 32'ha5a5_a5a5, 7'd2);
    for (i = 0; i < 7; i++) send_request(ACT_READ, 32'h0, INDEX_W'(i));
    send_request(ACT_READ,   32'h0, 7'd64);
    send_request(ACT_REMOVE, 32'h0, 7'd6);
    send_request(ACT_REMOVE, 32'h0, 7'd5);
    send_request(ACT_REMOVE, 32'h0, 7'd0);
    send_request(ACT_REMOVE, 32'h0, 7'd1);
    for (i = 0; i < 3; i++) send_request(ACT_READ, 32'h0, INDEX_W'(i));
  endtask

  // random phases; the first one grows the list toward full
  task automatic run_random(input int unsigned goal);
    phase_t      phase;
    int unsigned phase_len;
    int unsigned done_items;
    int unsigned k;
    int unsigned roll;
    action_t     act;
    phase      = PH_GROW;
    phase_len  = 110;
    done_items = 0;
    while (done_items < goal) begin
      for (k = 0; k < phase_len && done_items < goal; k++) begin
        roll = $urandom_range(0, 99);
        case (phase)
          PH_GROW:   act = roll < 45 ? ACT_APPEND : roll < 75 ? ACT_INSERT :
                           roll < 85 ? ACT_REMOVE : ACT_READ;
          PH_SHRINK: act = roll < 10 ? ACT_APPEND : roll < 20 ? ACT_INSERT :
                           roll < 70 ? ACT_REMOVE : ACT_READ;
          default:   act = action_t'(roll % 4);
        endcase
        send_request(act, pick_value(), pick_index(act, sb.fill));
        done_items++;
      end
      phase     = phase_t'($urandom_range(0, 2));
      phase_len = $urandom_range(30, 120);
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(RANDOM_ITEMS);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();
    $display("ran %0d requests: %0d append, %0d insert, %0d remove, %0d read",
             sent, sb.action_hits[ACT_APPEND], sb.action_hits[ACT_INSERT],
             sb.action_hits[ACT_REMOVE], sb.action_hits[ACT_READ]);
    $display("outcomes: %0d done, %0d bad position, %0d list full; %0d words compared",
             sb.status_hits[ST_DONE], sb.status_hits[ST_INDEX],
             sb.status_hits[ST_FULL], sb.compared);
    if (sb.mismatches == 0) begin
      $display("insertable_int_array regression: pass");
    end else begin
      $display("insertable_int_array regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15_000_000;
    $display("insertable_int_array regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/iia_pkg.sv
src/insertable_int_array.sv
verif/testbench.sv
